// File: src/scl_pkg.sv
// Shared types and character constants for the shell command lexer.
// No dependencies; every other file of the block uses this package.
package scl_pkg;

	localparam int unsigned KindWidth = 4;
	localparam int unsigned QueueDepth = 4;
	localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);
	localparam int unsigned QueueCntWidth = $clog2(QueueDepth + 1);

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_PIPE = 8'h7C;
	localparam logic [7:0] CH_AMP = 8'h26;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_LT = 8'h3C;
	localparam logic [7:0] CH_GT = 8'h3E;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;
	localparam logic [7:0] CH_CR = 8'h0D;

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'd0,
		MODE_PIPE   = 3'd1,
		MODE_AMP    = 3'd2,
		MODE_WORD   = 3'd3,
		MODE_SQUOTE = 3'd4,
		MODE_DQUOTE = 3'd5
	} lex_mode_t;

	typedef enum logic [KindWidth-1:0] {
		K_BYTE = 4'd0,
		K_WEND = 4'd1,
		K_PIPE = 4'd2,
		K_OR   = 4'd3,
		K_AND  = 4'd4,
		K_AMP  = 4'd5,
		K_SEMI = 4'd6,
		K_IN   = 4'd7,
		K_OUT  = 4'd8,
		K_END  = 4'd9,
		K_QERR = 4'd10
	} kind_t;

	// Outcome of lexing one byte: up to two results, first one in kind0.
	typedef struct packed {
		lex_mode_t  next_mode;
		logic [1:0] count;
		kind_t      kind0;
		kind_t      kind1;
	} step_res_t;

endpackage

// File: src/scl_step.sv
// Combinational lexer step: current mode and one byte in, next mode and results out.
// Depends on scl_pkg.
module scl_step (
	input  scl_pkg::lex_mode_t mode,
	input  logic [7:0]         char_in,
	output scl_pkg::step_res_t res
);

	typedef struct packed {
		logic               has;
		scl_pkg::kind_t     kind;
		scl_pkg::lex_mode_t mode;
	} idle_res_t;

	// Handling of a byte between tokens.
	function automatic idle_res_t idle_step(input logic [7:0] c);
		idle_res_t r;
		r.has = 1'b1;
		r.kind = scl_pkg::K_BYTE;
		r.mode = scl_pkg::MODE_IDLE;
		if (c == scl_pkg::CH_NUL) begin
			r.kind = scl_pkg::K_END;
		end else if (c inside {[scl_pkg::CH_TAB:scl_pkg::CH_CR], scl_pkg::CH_SPACE}) begin
			r.has = 1'b0;
		end else if (c == scl_pkg::CH_SEMI) begin
			r.kind = scl_pkg::K_SEMI;
		end else if (c == scl_pkg::CH_LT) begin
			r.kind = scl_pkg::K_IN;
		end else if (c == scl_pkg::CH_GT) begin
			r.kind = scl_pkg::K_OUT;
		end else if (c == scl_pkg::CH_PIPE) begin
			r.has = 1'b0;
			r.mode = scl_pkg::MODE_PIPE;
		end else if (c == scl_pkg::CH_AMP) begin
			r.has = 1'b0;
			r.mode = scl_pkg::MODE_AMP;
		end else if (c == scl_pkg::CH_SQUOTE) begin
			r.has = 1'b0;
			r.mode = scl_pkg::MODE_SQUOTE;
		end else if (c == scl_pkg::CH_DQUOTE) begin
			r.has = 1'b0;
			r.mode = scl_pkg::MODE_DQUOTE;
		end else begin
			r.mode = scl_pkg::MODE_WORD;
		end
		return r;
	endfunction

	idle_res_t  idle_r;
	logic       word_break;
	logic [7:0] close_char;

	assign idle_r = idle_step(char_in);

	// Newline is word content; the other whitespace bytes end a word.
	assign word_break = char_in inside {scl_pkg::CH_NUL, scl_pkg::CH_SPACE, scl_pkg::CH_TAB,
		scl_pkg::CH_VT, scl_pkg::CH_FF, scl_pkg::CH_CR, scl_pkg::CH_PIPE, scl_pkg::CH_LT,
		scl_pkg::CH_GT, scl_pkg::CH_SEMI, scl_pkg::CH_AMP};

	assign close_char = (mode == scl_pkg::MODE_SQUOTE) ? scl_pkg::CH_SQUOTE : scl_pkg::CH_DQUOTE;

	always_comb begin
		res.next_mode = idle_r.mode;
		res.count = {1'b0, idle_r.has};
		res.kind0 = idle_r.kind;
		res.kind1 = idle_r.kind;
		case (mode)
			scl_pkg::MODE_PIPE, scl_pkg::MODE_AMP: begin
				if ((mode == scl_pkg::MODE_PIPE && char_in == scl_pkg::CH_PIPE)
					|| (mode == scl_pkg::MODE_AMP && char_in == scl_pkg::CH_AMP)) begin
					res.next_mode = scl_pkg::MODE_IDLE;
					res.count = 2'd1;
					res.kind0 = (mode == scl_pkg::MODE_PIPE) ? scl_pkg::K_OR : scl_pkg::K_AND;
				end else begin
					res.count = idle_r.has ? 2'd2 : 2'd1;
					res.kind0 = (mode == scl_pkg::MODE_PIPE) ? scl_pkg::K_PIPE : scl_pkg::K_AMP;
				end
			end
			scl_pkg::MODE_WORD: begin
				if (char_in == scl_pkg::CH_SQUOTE) begin
					res.next_mode = scl_pkg::MODE_SQUOTE;
					res.count = 2'd0;
				end else if (char_in == scl_pkg::CH_DQUOTE) begin
					res.next_mode = scl_pkg::MODE_DQUOTE;
					res.count = 2'd0;
				end else if (word_break) begin
					res.count = idle_r.has ? 2'd2 : 2'd1;
					res.kind0 = scl_pkg::K_WEND;
				end else begin
					res.next_mode = scl_pkg::MODE_WORD;
					res.count = 2'd1;
					res.kind0 = scl_pkg::K_BYTE;
				end
			end
			scl_pkg::MODE_SQUOTE, scl_pkg::MODE_DQUOTE: begin
				if (char_in == scl_pkg::CH_NUL) begin
					res.next_mode = scl_pkg::MODE_IDLE;
					res.count = 2'd1;
					res.kind0 = scl_pkg::K_QERR;
				end else if (char_in == close_char) begin
					res.next_mode = scl_pkg::MODE_WORD;
					res.count = 2'd0;
				end else begin
					res.next_mode = mode;
					res.count = 2'd1;
					res.kind0 = scl_pkg::K_BYTE;
				end
			end
			default: begin
				res.next_mode = idle_r.mode;
			end
		endcase
	end

endmodule

// File: src/scl_out_queue.sv
// Result queue: takes up to two results per cycle while it has room, hands out one per cycle while out_ready is high.
// Depends on scl_pkg.
module scl_out_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  scl_pkg::step_res_t  res,
	output logic                room,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [scl_pkg::KindWidth-1:0] kind
);

	scl_pkg::kind_t mem_q [scl_pkg::QueueDepth];
	logic [scl_pkg::QueuePtrWidth-1:0] wr_ptr_q;
	logic [scl_pkg::QueuePtrWidth-1:0] rd_ptr_q;
	logic [scl_pkg::QueueCntWidth-1:0] count_q;
	logic [scl_pkg::QueueCntWidth-1:0] count_after_pop;
	logic [1:0]                        n_push;
	logic                              pop;

	assign out_valid = (count_q != '0);
	assign pop = out_valid && out_ready;
	assign kind = mem_q[rd_ptr_q];
	assign n_push = push ? res.count : 2'd0;
	assign count_after_pop = count_q - scl_pkg::QueueCntWidth'(pop);
	// Space for the worst case of two results, counting this cycle's pop.
	assign room = (count_after_pop <= scl_pkg::QueueCntWidth'(scl_pkg::QueueDepth - 2));

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			mem_q[wr_ptr_q] <= res.kind0;
		end
		if (n_push == 2'd2) begin
			mem_q[wr_ptr_q + scl_pkg::QueuePtrWidth'(1)] <= res.kind1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + scl_pkg::QueuePtrWidth'(n_push);
			rd_ptr_q <= rd_ptr_q + scl_pkg::QueuePtrWidth'(pop);
			count_q <= count_after_pop + scl_pkg::QueueCntWidth'(n_push);
		end
	end

endmodule

// File: src/shell_command_lexer.sv
// Shell command lexer: one byte per cycle in, tokens out through a four-entry result queue.
// A byte is registered in the input stage, then its results are written into the queue and read out on kind.
// Throughput: one byte per cycle while the output takes one result per cycle; a byte that
// yields two results (word end or pending operator plus a token) needs two output handshakes.
// Reset (arst_n low) empties the input stage and the queue and returns the lexer to idle.
// Depends on scl_pkg, scl_step and scl_out_queue.
module shell_command_lexer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] kind
);

	logic               valid_s1;
	logic [7:0]         char_s1;
	scl_pkg::lex_mode_t mode_q;
	scl_pkg::step_res_t step_res;
	logic               room;
	logic               advance;

	assign advance = valid_s1 && room;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q <= scl_pkg::MODE_IDLE;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				mode_q <= step_res.next_mode;
			end
		end
	end

	scl_step u_step (
		.mode    (mode_q),
		.char_in (char_s1),
		.res     (step_res)
	);

	scl_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance),
		.res       (step_res),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind)
	);

endmodule
